/* sv/obstacle_avoid_drive_sequencer_macros.svh */
// Assertion macros shared by the obstacle avoid drive sequencer RTL.
// No dependencies; the asserting file must have clk and rst_n in scope.
`ifndef OBSTACLE_AVOID_DRIVE_SEQUENCER_MACROS_SVH
`define OBSTACLE_AVOID_DRIVE_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define OADS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oads assertion failed");
`define OADS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oads assertion failed");
`else
`define OADS_ASSERT_SAME(lbl, ante, cons)
`define OADS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/oads_pkg.sv */
// Shared types and constants for the obstacle avoid drive sequencer.
// No dependencies.
package oads_pkg;

  localparam int unsigned ECHO_W   = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned DEBNC_W  = 20;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DRIVE_W  = 2;

  localparam int unsigned NUM_LANES  = 3;
  localparam int unsigned LANE_FRONT = 0;
  localparam int unsigned LANE_LEFT  = 1;
  localparam int unsigned LANE_RIGHT = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBST_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_TARGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_PULSE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd3;

  localparam logic [ECHO_W-1:0]  RST_OBST_LIMIT = 16'd1749;
  localparam logic [COUNT_W-1:0] RST_FWD_TARGET = 16'd281;
  localparam logic [COUNT_W-1:0] RST_TURN_PULSE = 16'd31;
  localparam logic [DEBNC_W-1:0] RST_DEBOUNCE   = 20'd1000;

  // drive command codes
  localparam logic [DRIVE_W-1:0] DRIVE_STOP    = 2'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_FORWARD = 2'd1;
  localparam logic [DRIVE_W-1:0] DRIVE_LEFT    = 2'd2;
  localparam logic [DRIVE_W-1:0] DRIVE_RIGHT   = 2'd3;

  typedef struct packed {
    logic front;
    logic left;
    logic right;
  } obst_t;

  typedef struct packed {
    logic [ECHO_W-1:0]  obst_limit;
    logic [COUNT_W-1:0] fwd_target;
    logic [COUNT_W-1:0] turn_pulse;
    logic [DEBNC_W-1:0] debounce;
  } cfg_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               finished;
    logic [COUNT_W-1:0] pulse_total;
  } result_t;

endpackage

/* sv/oads_echo_lane.sv */
// One echo lane: classifies a single sensor echo as obstacle or clear.
// Depends on oads_pkg.
module oads_echo_lane (
  input  logic [oads_pkg::ECHO_W-1:0] echo_us,
  input  logic                        echo_valid,
  input  logic [oads_pkg::ECHO_W-1:0] limit_us,
  output logic                        obstacle
);

  // timed-out or zero echoes never count as an obstacle
  assign obstacle = echo_valid && (echo_us != '0) && (echo_us <= limit_us);

endmodule

/* sv/oads_mode_ctl.sv */
// Drive mode sequencer: merges lane findings with the pulse counter.
// Depends on oads_pkg.
module oads_mode_ctl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          beat_en,
  input  logic                          func,
  input  logic [oads_pkg::STAMP_W-1:0]  stamp_us,
  input  oads_pkg::obst_t               obst,
  input  oads_pkg::cfg_t                cfg,
  output oads_pkg::result_t             res_nxt,
  output oads_pkg::result_t             status
);

  typedef enum logic [2:0] {
    M_STOPPED  = 3'd0,
    M_FORWARD  = 3'd1,
    M_LEFT     = 3'd2,
    M_RIGHT    = 3'd3,
    M_FINISHED = 3'd4
  } mode_t;

  mode_t                         mode_r, mode_nxt;
  logic [oads_pkg::COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [oads_pkg::STAMP_W-1:0]  last_r, last_nxt;
  logic [oads_pkg::STAMP_W-1:0]  gap;
  logic                          active;
  logic                          turning;

  assign gap     = stamp_us - last_r;
  assign turning = (mode_r == M_LEFT) || (mode_r == M_RIGHT);
  assign active  = turning || (mode_r == M_FORWARD);

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (active && !func) begin
      // encoder edge: debounce, saturating count, then turn completion
      if (gap > {{(oads_pkg::STAMP_W-oads_pkg::DEBNC_W){1'b0}}, cfg.debounce}) begin
        if (cnt_r != '1) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        last_nxt = stamp_us;
      end
      if (turning && (cnt_nxt >= cfg.turn_pulse)) begin
        mode_nxt = (cnt_nxt >= cfg.fwd_target) ? M_FINISHED : M_FORWARD;
      end
    end else if (mode_r == M_FORWARD) begin
      // sensing round in forward mode
      if (obst.front) begin
        if (obst.left && obst.right) begin
          mode_nxt = M_FINISHED;
        end else begin
          cnt_nxt = '0;
          if (cfg.turn_pulse == '0) begin
            // turn done at once, then the target check on a cleared count
            mode_nxt = (cfg.fwd_target == '0) ? M_FINISHED : M_FORWARD;
          end else begin
            mode_nxt = obst.left ? M_RIGHT : M_LEFT;
          end
        end
      end else if (cnt_r >= cfg.fwd_target) begin
        mode_nxt = M_FINISHED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_FORWARD;
      cnt_r  <= '0;
      last_r <= '0;
    end else if (beat_en) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
    end
  end

  always_comb begin
    res_nxt.pulse_total = cnt_nxt;
    res_nxt.finished    = (mode_nxt == M_FINISHED);
    case (mode_nxt)
      M_FORWARD: res_nxt.drive = oads_pkg::DRIVE_FORWARD;
      M_LEFT:    res_nxt.drive = oads_pkg::DRIVE_LEFT;
      M_RIGHT:   res_nxt.drive = oads_pkg::DRIVE_RIGHT;
      default:   res_nxt.drive = oads_pkg::DRIVE_STOP;
    endcase
  end

  always_comb begin
    status.pulse_total = cnt_r;
    status.finished    = (mode_r == M_FINISHED);
    case (mode_r)
      M_FORWARD: status.drive = oads_pkg::DRIVE_FORWARD;
      M_LEFT:    status.drive = oads_pkg::DRIVE_LEFT;
      M_RIGHT:   status.drive = oads_pkg::DRIVE_RIGHT;
      default:   status.drive = oads_pkg::DRIVE_STOP;
    endcase
  end

endmodule

/* sv/obstacle_avoid_drive_sequencer.sv */
// Obstacle avoid drive sequencer, top level: config registers, echo lanes,
// mode sequencer and the output register. Depends on oads_pkg and the macros.
// The result is registered and offered in the cycle after its input beat; one beat per
// cycle sustained while out_ready allows, as oads_mode_ctl updates mode and count on each beat.
// Reset (synchronous, rst_n low): mode forward, count and last edge zero,
// config registers to their defaults, output register empty.
`include "obstacle_avoid_drive_sequencer_macros.svh"

module obstacle_avoid_drive_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [oads_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [oads_pkg::CFG_W-1:0]      cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [oads_pkg::STAMP_W-1:0]    in_stamp_us,
  input  logic [oads_pkg::ECHO_W-1:0]     in_front_echo_us,
  input  logic                            in_front_valid,
  input  logic [oads_pkg::ECHO_W-1:0]     in_left_echo_us,
  input  logic                            in_left_valid,
  input  logic [oads_pkg::ECHO_W-1:0]     in_right_echo_us,
  input  logic                            in_right_valid,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [oads_pkg::DRIVE_W-1:0]    out_drive,
  output logic                            out_finished,
  output logic [oads_pkg::COUNT_W-1:0]    out_pulse_total
);

  oads_pkg::cfg_t     cfg_r;
  oads_pkg::obst_t    obst;
  oads_pkg::result_t  res_nxt;
  oads_pkg::result_t  status;
  oads_pkg::result_t  out_r;
  logic               out_valid_r;
  logic               in_beat;
  logic [oads_pkg::NUM_LANES-1:0]  lane_hit;
  logic [oads_pkg::ECHO_W-1:0]     lane_echo  [oads_pkg::NUM_LANES];
  logic [oads_pkg::NUM_LANES-1:0]  lane_valid;

  // Config writes land directly; an index with no register is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.obst_limit <= oads_pkg::RST_OBST_LIMIT;
      cfg_r.fwd_target <= oads_pkg::RST_FWD_TARGET;
      cfg_r.turn_pulse <= oads_pkg::RST_TURN_PULSE;
      cfg_r.debounce   <= oads_pkg::RST_DEBOUNCE;
    end else if (cfg_we) begin
      case (cfg_index)
        oads_pkg::REG_OBST_LIMIT: cfg_r.obst_limit <= cfg_data[oads_pkg::ECHO_W-1:0];
        oads_pkg::REG_FWD_TARGET: cfg_r.fwd_target <= cfg_data[oads_pkg::COUNT_W-1:0];
        oads_pkg::REG_TURN_PULSE: cfg_r.turn_pulse <= cfg_data[oads_pkg::COUNT_W-1:0];
        oads_pkg::REG_DEBOUNCE:   cfg_r.debounce   <= cfg_data[oads_pkg::DEBNC_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a new beat whenever the output register is empty or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign in_beat  = in_valid && in_ready;

  // Three echo lanes run side by side on the sensing round.
  assign lane_echo[oads_pkg::LANE_FRONT]  = in_front_echo_us;
  assign lane_echo[oads_pkg::LANE_LEFT]   = in_left_echo_us;
  assign lane_echo[oads_pkg::LANE_RIGHT]  = in_right_echo_us;
  assign lane_valid[oads_pkg::LANE_FRONT] = in_front_valid;
  assign lane_valid[oads_pkg::LANE_LEFT]  = in_left_valid;
  assign lane_valid[oads_pkg::LANE_RIGHT] = in_right_valid;

  for (genvar g = 0; g < oads_pkg::NUM_LANES; g++) begin : g_lane
    oads_echo_lane u_lane (
      .echo_us    (lane_echo[g]),
      .echo_valid (lane_valid[g]),
      .limit_us   (cfg_r.obst_limit),
      .obstacle   (lane_hit[g])
    );
  end

  assign obst.front = lane_hit[oads_pkg::LANE_FRONT];
  assign obst.left  = lane_hit[oads_pkg::LANE_LEFT];
  assign obst.right = lane_hit[oads_pkg::LANE_RIGHT];

  // Merge stage: mode, pulse count and last edge time advance on each beat.
  oads_mode_ctl u_mode (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat_en  (in_beat),
    .func     (in_func),
    .stamp_us (in_stamp_us),
    .obst     (obst),
    .cfg      (cfg_r),
    .res_nxt  (res_nxt),
    .status   (status)
  );

  // Output register: load on an input beat, drop after the result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive       = out_r.drive;
  assign out_finished    = out_r.finished;
  assign out_pulse_total = out_r.pulse_total;

  // Finished is terminal.
  `OADS_ASSERT_NEXT(a_finished_sticky, status.finished, status.finished)
  // A finished run always drives stop.
  `OADS_ASSERT_SAME(a_finished_stops, status.finished, status.drive == oads_pkg::DRIVE_STOP)
  // Encoder edges never lower the pulse count.
  `OADS_ASSERT_NEXT(a_edge_no_drop, in_beat && !in_func,
                    status.pulse_total >= $past(status.pulse_total))
  // Every accepted beat leaves a result waiting, matching the new state.
  `OADS_ASSERT_NEXT(a_beat_result, in_beat,
                    out_valid_r && (out_r.pulse_total == status.pulse_total))

endmodule
